>>> rtl/core/keyboard_report_to_key_events_core_defines.svh
// ----------------------------------------------------------------------------
// keyboard report to key events - assertion macros
// shared property templates for the core's checks
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_REPORT_TO_KEY_EVENTS_CORE_DEFINES_SVH
`define KEYBOARD_REPORT_TO_KEY_EVENTS_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define KRE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kre check failed");

// next-cycle implication, disabled in reset
`define KRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kre check failed");

`endif

>>> rtl/core/kre_pkg.sv
// ----------------------------------------------------------------------------
// kre_pkg
// types, constants and lookup shared by the key event core
// ----------------------------------------------------------------------------
`default_nettype none

package kre_pkg;

  localparam int PAYLOAD_W = 56;
  localparam int CNT_W     = 6;

  // report ids
  localparam logic [7:0] ID_CONSUMER = 8'd1;
  localparam logic [7:0] ID_PAGE4    = 8'd4;
  localparam logic [7:0] ID_PAGE5    = 8'd5;
  localparam logic [7:0] ID_PAGE6    = 8'd6;

  // key index bases; first bitmap key sits eight indices above the base
  localparam int BASE_PAGE4 = 0;
  localparam int BASE_PAGE5 = 64;
  localparam int BASE_PAGE6 = 192;
  localparam logic [7:0] FIRST_PAGE4 = 8'(BASE_PAGE4 + 8);
  localparam logic [7:0] FIRST_PAGE5 = 8'(BASE_PAGE5 + 8);
  localparam logic [7:0] FIRST_PAGE6 = 8'(BASE_PAGE6 + 8);
  localparam logic [7:0] BASE_CONSUMER = 8'd128;

  // item kinds
  localparam logic ITEM_KEY  = 1'b0;
  localparam logic ITEM_SYNC = 1'b1;

  localparam int NUM_CODES = 11;
  localparam logic [7:0] CONSUMER_CODES [NUM_CODES] = '{
    8'd234, 8'd233, 8'd131, 8'd226, 8'd183, 8'd182,
    8'd205, 8'd181, 8'd138, 8'd35,  8'd146
  };

  typedef struct packed {
    logic [7:0]           report_id;
    logic [PAYLOAD_W-1:0] payload;
  } rpt_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] key_index;
    logic       pressed;
    logic       last;
  } evt_t;

  typedef struct packed {
    logic hit;
    logic [3:0] idx;
  } code_hit_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic advance;
    logic emit_key;
    logic emit_cons;
    logic emit_sync;
  } kre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_bitmap;
    logic in_consumer;
    logic bit_set;
    logic bit_last;
    logic out_free;
    logic cons_pend;
  } kre_sts_t;

  // match a consumer code against the known list
  function automatic code_hit_t consumer_lookup(input logic [7:0] code);
    code_hit_t r;
    r.hit = 1'b0;
    r.idx = 4'd0;
    for (int c = 0; c < NUM_CODES; c++) begin
      if (code == CONSUMER_CODES[c]) begin
        r.hit = 1'b1;
        r.idx = 4'(c);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/kre_ctrl.sv
// ----------------------------------------------------------------------------
// kre_ctrl
// sequencer: capture, bitmap scan, consumer events, sync
// ----------------------------------------------------------------------------
`default_nettype none

module kre_ctrl import kre_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     rpt_valid,
  output logic          rpt_stall,
  input  wire kre_sts_t sts,
  output kre_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CONS = 2'd2;
  localparam logic [1:0] ST_SYNC = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign rpt_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (rpt_valid) begin
          cmd.capture = 1'b1;
          if (sts.in_bitmap) begin
            state_next = ST_SCAN;
          end else if (sts.in_consumer) begin
            state_next = ST_CONS;
          end else begin
            state_next = ST_SYNC;
          end
        end
      end
      ST_SCAN: begin
        if (!sts.bit_set || sts.out_free) begin
          cmd.advance  = 1'b1;
          cmd.emit_key = sts.bit_set;
          if (sts.bit_last) begin
            state_next = ST_SYNC;
          end
        end
      end
      ST_CONS: begin
        if (!sts.cons_pend) begin
          state_next = ST_SYNC;
        end else if (sts.out_free) begin
          cmd.emit_cons = 1'b1;
        end
      end
      ST_SYNC: begin
        if (sts.out_free) begin
          cmd.emit_sync = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/kre_dp.sv
// ----------------------------------------------------------------------------
// kre_dp
// page copies, difference shifter, consumer event slots and output register
// ----------------------------------------------------------------------------
`default_nettype none

module kre_dp import kre_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire rpt_t     rpt,
  output evt_t          evt,
  output logic          evt_valid,
  input  wire logic     evt_stall,
  input  wire kre_cmd_t cmd,
  output kre_sts_t      sts
);

  logic [PAYLOAD_W-1:0] prev_page4;
  logic [PAYLOAD_W-1:0] prev_page5;
  logic [PAYLOAD_W-1:0] prev_page6;
  logic [7:0]           prev_cons;

  logic [PAYLOAD_W-1:0] diff;
  logic [PAYLOAD_W-1:0] now_bits;
  logic [7:0]           key_idx;
  logic [CNT_W-1:0]     bit_cnt;

  // two consumer event slots, slot 0 goes out first
  logic       s0_v, s1_v;
  logic [7:0] s0_idx, s1_idx;
  logic       s0_pr, s1_pr;

  // capture-time values
  logic [PAYLOAD_W-1:0] prev_sel;
  logic [7:0]           first_sel;
  code_hit_t            now_hit, old_hit;
  logic                 differ, press_v, rel_v;
  logic [7:0]           press_idx, rel_idx;
  logic                 c0_v, c1_v, c0_pr, c1_pr;
  logic [7:0]           c0_idx, c1_idx;

  // status to controller
  assign sts.in_bitmap   = (rpt.report_id == ID_PAGE4) || (rpt.report_id == ID_PAGE5) ||
                           (rpt.report_id == ID_PAGE6);
  assign sts.in_consumer = (rpt.report_id == ID_CONSUMER);
  assign sts.bit_set     = diff[0];
  assign sts.bit_last    = (bit_cnt == CNT_W'(PAYLOAD_W - 1));
  assign sts.out_free    = !evt_valid || !evt_stall;
  assign sts.cons_pend   = s0_v;

  // pick the stored page and first key index
  always_comb begin
    case (rpt.report_id)
      ID_PAGE4: begin
        prev_sel  = prev_page4;
        first_sel = FIRST_PAGE4;
      end
      ID_PAGE5: begin
        prev_sel  = prev_page5;
        first_sel = FIRST_PAGE5;
      end
      ID_PAGE6: begin
        prev_sel  = prev_page6;
        first_sel = FIRST_PAGE6;
      end
      default: begin
        prev_sel  = '0;
        first_sel = FIRST_PAGE4;
      end
    endcase
  end

  // consumer press and release, ordered by code position
  always_comb begin
    now_hit   = consumer_lookup(rpt.payload[7:0]);
    old_hit   = consumer_lookup(prev_cons);
    differ    = (rpt.payload[7:0] != prev_cons);
    press_v   = now_hit.hit && differ;
    rel_v     = old_hit.hit && differ;
    press_idx = BASE_CONSUMER + {4'd0, now_hit.idx};
    rel_idx   = BASE_CONSUMER + {4'd0, old_hit.idx};
    c0_v   = press_v || rel_v;
    c1_v   = press_v && rel_v;
    c0_idx = rel_idx;
    c0_pr  = 1'b0;
    c1_idx = press_idx;
    c1_pr  = 1'b1;
    if (press_v && (!rel_v || (now_hit.idx < old_hit.idx))) begin
      c0_idx = press_idx;
      c0_pr  = 1'b1;
      c1_idx = rel_idx;
      c1_pr  = 1'b0;
    end
  end

  // control registers and page copies
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid  <= 1'b0;
      s0_v       <= 1'b0;
      s1_v       <= 1'b0;
      bit_cnt    <= '0;
      prev_page4 <= '0;
      prev_page5 <= '0;
      prev_page6 <= '0;
      prev_cons  <= '0;
    end else begin
      if (cmd.emit_key || cmd.emit_cons || cmd.emit_sync) begin
        evt_valid <= 1'b1;
      end else if (!evt_stall) begin
        evt_valid <= 1'b0;
      end
      if (cmd.capture) begin
        bit_cnt <= '0;
        case (rpt.report_id)
          ID_CONSUMER: begin
            prev_cons <= rpt.payload[7:0];
            s0_v      <= c0_v;
            s1_v      <= c1_v;
          end
          ID_PAGE4: prev_page4 <= rpt.payload;
          ID_PAGE5: prev_page5 <= rpt.payload;
          ID_PAGE6: prev_page6 <= rpt.payload;
          default: begin
          end
        endcase
      end else begin
        if (cmd.advance) begin
          bit_cnt <= bit_cnt + CNT_W'(1);
        end
        if (cmd.emit_cons) begin
          s0_v <= s1_v;
          s1_v <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      diff     <= rpt.payload ^ prev_sel;
      now_bits <= rpt.payload;
      key_idx  <= first_sel;
      s0_idx   <= c0_idx;
      s0_pr    <= c0_pr;
      s1_idx   <= c1_idx;
      s1_pr    <= c1_pr;
    end else begin
      if (cmd.advance) begin
        diff     <= diff >> 1;
        now_bits <= now_bits >> 1;
        key_idx  <= key_idx + 8'd1;
      end
      if (cmd.emit_cons) begin
        s0_idx <= s1_idx;
        s0_pr  <= s1_pr;
      end
    end
    // output register
    if (cmd.emit_key) begin
      evt.item_kind <= ITEM_KEY;
      evt.key_index <= key_idx;
      evt.pressed   <= now_bits[0];
      evt.last      <= 1'b0;
    end else if (cmd.emit_cons) begin
      evt.item_kind <= ITEM_KEY;
      evt.key_index <= s0_idx;
      evt.pressed   <= s0_pr;
      evt.last      <= 1'b0;
    end else if (cmd.emit_sync) begin
      evt.item_kind <= ITEM_SYNC;
      evt.key_index <= 8'd0;
      evt.pressed   <= 1'b0;
      evt.last      <= 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/keyboard_report_to_key_events_core.sv
// ----------------------------------------------------------------------------
// keyboard_report_to_key_events_core
// turns keyboard reports into key press/release events and a sync item
//
// channel  dir  payload  transaction
// rpt      in   rpt_t    one report: id byte and 56 payload bits
// evt      out  evt_t    one key event, or the sync item closing a report
//
// bitmap reports (ids 4, 5, 6): capture, a scan of the payload bits in
// the difference shifter, then the sync item. consumer reports (id 1)
// give up to two events before sync, other ids only the sync item.
// stalls on evt add cycles only where an event is waiting to go out.
// a new report is taken while the final sync item still waits in the
// output register. reset clears all stored pages and the consumer code.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyboard_report_to_key_events_core_defines.svh"

module keyboard_report_to_key_events_core import kre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic rpt_valid,
  output logic      rpt_stall,
  input  wire rpt_t rpt,
  output logic      evt_valid,
  input  wire logic evt_stall,
  output evt_t      evt
);

  kre_cmd_t cmd;
  kre_sts_t sts;

  // sequencer
  kre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  kre_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .rpt       (rpt),
    .evt       (evt),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // busy right after a report is taken
  `KRE_ASSERT_NEXT(a_busy_after_capture, clk, rst, rpt_valid && !rpt_stall, rpt_stall)
  // key events only go out while a report is still in work
  `KRE_ASSERT_SAME(a_key_while_busy, clk, rst, evt_valid && (evt.item_kind == ITEM_KEY), rpt_stall)
  // a stalled event stays valid and unchanged
  `KRE_ASSERT_NEXT(a_evt_held, clk, rst, evt_valid && evt_stall, evt_valid && $stable(evt))

endmodule

`default_nettype wire

>>> dv/keyboard_report_to_key_events_core_tb.sv
// ----------------------------------------------------------------------------
// keyboard_report_to_key_events_core_tb
// self-checking bench for the keyboard report to key event core. a directed
// table covers unknown ids, single-bit and full-page bitmap changes, the
// outermost key indices and every consumer code. random reports follow,
// most bitmap ones flipping one to three stored keys. events are checked
// against a behavioral model of the core or the table's typed rows, under
// three idle mixes and one long output hold.
// ----------------------------------------------------------------------------
module keyboard_report_to_key_events_core_tb import kre_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES = 7;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          RANDOM_ITEMS = 145;
  localparam logic [55:0] ALL_ONES     = {56{1'b1}};
  localparam logic [55:0] TOP_BIT      = 56'h80_0000_0000_0000;

  // consumer codes in scan order, key index 128 + position
  localparam logic [7:0] MEDIA_CODES [11] = '{
    8'd234, 8'd233, 8'd131, 8'd226, 8'd183, 8'd182,
    8'd205, 8'd181, 8'd138, 8'd35,  8'd146
  };
  localparam int PAGE_BASES [3] = '{0, 64, 192};

  localparam evt_t SYNC_ITEM = '{item_kind: ITEM_SYNC, key_index: 8'd0,
                                 pressed: 1'b0, last: 1'b1};

  typedef struct packed {
    rpt_t           report;
    logic [1:0]     n_typed;
    evt_t [2:0]     typed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic rpt_valid;
  logic rpt_stall;
  rpt_t rpt;
  logic evt_valid;
  logic evt_stall;
  evt_t evt;

  // model state of the core
  logic [7:0]  held_media_code;
  logic [55:0] page_bits [3];

  evt_t      key_events_run [$];
  evt_t      pending_events [$];
  stim_row_t directed_rows [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          holds_asked;
  int          holds_done;
  int          hold_left;
  int          fail_count;
  int          events_checked;
  int          cycle_count;
  int          input_stall_cycles;
  int          bitmap_reports;
  int          media_reports;
  int          ignored_reports;

  keyboard_report_to_key_events_core DUT (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic evt_t key_evt(input int idx, input logic down);
    evt_t e;
    e.item_kind = ITEM_KEY;
    e.key_index = 8'(idx);
    e.pressed   = down;
    e.last      = 1'b0;
    return e;
  endfunction

  // events one report causes; updates the model state
  function automatic void predict_key_events(input rpt_t r);
    logic [7:0]  now_code;
    logic [55:0] diff;
    int          pg;
    key_events_run.delete();
    case (r.report_id)
      ID_CONSUMER: begin
        now_code = r.payload[7:0];
        for (int c = 0; c < 11; c++) begin
          if (now_code == MEDIA_CODES[c] && held_media_code != MEDIA_CODES[c])
            key_events_run.push_back(key_evt(128 + c, 1'b1));
          if (held_media_code == MEDIA_CODES[c] && now_code != MEDIA_CODES[c])
            key_events_run.push_back(key_evt(128 + c, 1'b0));
        end
        held_media_code = now_code;
      end
      ID_PAGE4, ID_PAGE5, ID_PAGE6: begin
        pg = int'(r.report_id - ID_PAGE4);
        diff = r.payload ^ page_bits[pg];
        page_bits[pg] = r.payload;
        for (int b = 0; b < 56; b++) begin
          if (diff[b])
            key_events_run.push_back(key_evt(PAGE_BASES[pg] + 8 + b, r.payload[b]));
        end
      end
      default: ;
    endcase
    key_events_run.push_back(SYNC_ITEM);
  endfunction

  task automatic add_row(input logic [7:0] id, input logic [55:0] pl, input int n,
                         input evt_t e0 = '0, input evt_t e1 = '0,
                         input evt_t e2 = '0);
    stim_row_t row;
    row.report.report_id = id;
    row.report.payload   = pl;
    row.n_typed          = 2'(n);
    row.typed            = {e2, e1, e0};
    directed_rows.push_back(row);
  endtask

  // random report; most bitmap reports flip one to three stored key bits
  function automatic rpt_t random_report();
    rpt_t        r;
    int unsigned sel;
    int unsigned pg;
    int unsigned bit_pos;
    sel = $urandom_range(99);
    r.payload = 56'({$urandom(), $urandom()});
    if (sel < 8) begin
      r.report_id = 8'($urandom_range(255));
    end else if (sel < 32) begin
      r.report_id = ID_CONSUMER;
      sel = $urandom_range(99);
      if (sel < 70)
        r.payload[7:0] = MEDIA_CODES[$urandom_range(10)];
      else if (sel < 85)
        r.payload[7:0] = 8'd0;
    end else begin
      pg = $urandom_range(2);
      r.report_id = ID_PAGE4 + 8'(pg);
      sel = $urandom_range(99);
      if (sel < 55) begin
        r.payload = page_bits[pg];
        repeat ($urandom_range(1, 3)) begin
          bit_pos = $urandom_range(55);
          r.payload[bit_pos] = ~r.payload[bit_pos];
        end
      end else if (sel < 70) begin
        r.payload = page_bits[pg];
      end else if (sel < 82) begin
        r.payload = '0;
      end
    end
    return r;
  endfunction

  // offer one report and wait until the core takes it
  task automatic offer_report(input rpt_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      rpt_valid <= 1'b0;
      @(posedge clk);
    end
    rpt_valid <= 1'b1;
    rpt       <= r;
    @(posedge clk);
    while (rpt_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    case (r.report_id)
      ID_CONSUMER:                  media_reports++;
      ID_PAGE4, ID_PAGE5, ID_PAGE6: bitmap_reports++;
      default:                      ignored_reports++;
    endcase
  endtask

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    fail_count++;
  endtask

  // output side: random stall, or a long hold when one is asked for
  initial begin
    evt_stall <= 1'b0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        evt_stall <= 1'b1;
        hold_left--;
      end else if (holds_done != holds_asked) begin
        evt_stall <= 1'b1;
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
      end else begin
        evt_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // compare each event transaction with the oldest expectation
  always @(posedge clk) begin : check_events
    evt_t want;
    if (!rst && evt_valid && !evt_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t ns: unexpected event, expected none, got kind %0d index %0d pressed %0d",
                 $realtime, evt.item_kind, evt.key_index, evt.pressed);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (evt.item_kind !== want.item_kind)
          report_field("item_kind", want.item_kind, evt.item_kind);
        if (evt.key_index !== want.key_index)
          report_field("key_index", want.key_index, evt.key_index);
        if (evt.pressed !== want.pressed)
          report_field("pressed", want.pressed, evt.pressed);
        if (evt.last !== want.last)
          report_field("last", want.last, evt.last);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected",
               cycle_count, pending_events.size());
      $display("keyboard_report_to_key_events_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst                <= 1'b1;
    rpt_valid          <= 1'b0;
    rpt                <= '0;
    cycle_count         = 0;
    fail_count          = 0;
    events_checked      = 0;
    input_stall_cycles  = 0;
    bitmap_reports      = 0;
    media_reports       = 0;
    ignored_reports     = 0;
    holds_asked         = 0;
    held_media_code     = 8'd0;
    page_bits           = '{default: '0};
    send_idle_pct       = 18;
    recv_idle_pct       = 85;

    // unknown ids, then bitmap extremes
    add_row(8'h00, ALL_ONES, 1, SYNC_ITEM);
    add_row(8'hFF, 56'd0, 1, SYNC_ITEM);
    add_row(ID_PAGE4, 56'd1, 2, key_evt(8, 1'b1), SYNC_ITEM);
    add_row(ID_PAGE4, 56'd0, 2, key_evt(8, 1'b0), SYNC_ITEM);
    add_row(ID_PAGE4, ALL_ONES, 0);
    add_row(ID_PAGE4, ALL_ONES, 1, SYNC_ITEM);
    add_row(ID_PAGE4, 56'd0, 0);
    add_row(ID_PAGE5, TOP_BIT, 2, key_evt(127, 1'b1), SYNC_ITEM);
    add_row(ID_PAGE6, TOP_BIT, 2, key_evt(255, 1'b1), SYNC_ITEM);
    add_row(ID_PAGE6, ALL_ONES, 0);
    add_row(ID_PAGE5, 56'hAA_AAAA_AAAA_AAAA, 0);
    // consumer codes: press, swap, release, unknown code
    add_row(ID_CONSUMER, 56'd234, 2, key_evt(128, 1'b1), SYNC_ITEM);
    add_row(ID_CONSUMER, 56'd146, 3, key_evt(128, 1'b0), key_evt(138, 1'b1), SYNC_ITEM);
    add_row(ID_CONSUMER, 56'd0, 2, key_evt(138, 1'b0), SYNC_ITEM);
    add_row(ID_CONSUMER, 56'd131, 2, key_evt(130, 1'b1), SYNC_ITEM);
    add_row(ID_CONSUMER, 56'd77, 2, key_evt(130, 1'b0), SYNC_ITEM);
    add_row(ID_CONSUMER, 56'd77, 1, SYNC_ITEM);
    add_row(ID_CONSUMER, {48'hFFFF_FFFF_FFFF, 8'd233}, 2, key_evt(129, 1'b1), SYNC_ITEM);
    add_row(ID_CONSUMER, 56'd226, 0);
    add_row(ID_CONSUMER, 56'd183, 0);
    add_row(ID_CONSUMER, 56'd182, 0);
    add_row(ID_CONSUMER, 56'd205, 0);
    add_row(ID_CONSUMER, 56'd181, 0);
    add_row(ID_CONSUMER, 56'd138, 0);
    add_row(ID_CONSUMER, 56'd35, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      offer_report(directed_rows[i].report);
      predict_key_events(directed_rows[i].report);
      if (directed_rows[i].n_typed != 0) begin
        for (int k = 0; k < directed_rows[i].n_typed; k++)
          pending_events.push_back(directed_rows[i].typed[k]);
      end else begin
        foreach (key_events_run[k]) pending_events.push_back(key_events_run[k]);
      end
    end

    // random reports over three idle mixes; long output hold in the last
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 18 : 0;
      if (ph == 2) holds_asked++;
      for (int n = 0; n < RANDOM_ITEMS / 3 + ((ph == 0) ? RANDOM_ITEMS % 3 : 0); n++) begin
        rpt_t r;
        r = random_report();
        offer_report(r);
        predict_key_events(r);
        foreach (key_events_run[k]) pending_events.push_back(key_events_run[k]);
      end
    end
    rpt_valid <= 1'b0;

    // drain, then watch for stray events
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d reports: %0d bitmap, %0d consumer, %0d ignored ids",
             bitmap_reports + media_reports + ignored_reports, bitmap_reports,
             media_reports, ignored_reports);
    $display("checked %0d events; report input held back for %0d cycles",
             events_checked, input_stall_cycles);
    if (fail_count == 0) begin
      $display("keyboard_report_to_key_events_core_tb: PASS");
    end else begin
      $display("keyboard_report_to_key_events_core_tb: FAIL");
    end
    $finish;
  end

endmodule
